// ===== design/rdz_pkg.sv =====
// ----------------------------------------------------------------------------
// rdz_pkg
// shared widths, reset values, register indexes and pipeline structs for the
// thumbstick radial dead zone unit
// ----------------------------------------------------------------------------
package rdz_pkg;

    localparam int AX_W   = 8;            // raw axis byte
    localparam int MAG_W  = 8;            // |raw - 127|, up to 128
    localparam int S_W    = 16;           // sum of squares, up to 32768
    localparam int ROOT_W = 24;           // floor(sqrt(s * 2^32))
    localparam int REM_W  = ROOT_W + 2;
    localparam int V_W    = 2 * ROOT_W;   // radicand s * 2^32
    localparam int MSQ_W  = 15;           // mag^2
    localparam int SDEN_W = 23;           // s * 127
    localparam int PROD_W = MSQ_W + ROOT_W;
    localparam int DPROD_W = SDEN_W + 17;
    localparam int NUM_W  = PROD_W + 16;  // 2 * 16384 * prod + den
    localparam int DEN_W  = DPROD_W + 1;  // 2 * den
    localparam int Q_W    = 16;
    localparam int DIV_W  = NUM_W + 2;
    localparam int DZ_W   = 16;
    localparam int OUT_W  = 16;

    localparam logic [AX_W-1:0] CENTER    = 8'd127;
    localparam logic [DZ_W-1:0] DZ_RESET  = 16'd6554;
    localparam logic            TCP_RESET = 1'b1;

    localparam logic REG_DEAD_ZONE   = 1'b0;
    localparam logic REG_TOUCH_PRESS = 1'b1;

    typedef struct packed {
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [S_W-1:0]   sum_sq;
    } rdz_vec_t;

    typedef struct packed {
        logic             touched;
        logic             neg_x;
        logic             neg_y;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den;
    } rdz_frac_t;

    typedef struct packed {
        logic touched;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } rdz_flags_t;

    typedef struct packed {
        rdz_flags_t     flags;
        logic [Q_W-1:0] q_x;
        logic [Q_W-1:0] q_y;
    } rdz_quo_t;

endpackage

// ===== design/rdz_sqrt.sv =====
// ----------------------------------------------------------------------------
// rdz_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module rdz_sqrt import rdz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              i_valid,
    output logic              i_ready,
    input  rdz_vec_t          i_vec,
    output logic              o_valid,
    input  logic              o_ready,
    output rdz_vec_t          o_vec,
    output logic [ROOT_W-1:0] o_root
);

    localparam int STAGES = ROOT_W;

    logic              valid_reg [STAGES];
    logic              rdy       [STAGES+1];
    rdz_vec_t          vec_reg   [STAGES];
    logic [V_W-1:0]    v_reg     [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [ROOT_W-1:0] root_reg  [STAGES];

    assign rdy[STAGES] = o_ready;
    assign i_ready     = rdy[0];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic              in_v;
        rdz_vec_t          in_vec;
        logic [V_W-1:0]    in_bits;
        logic [REM_W-1:0]  in_rem;
        logic [ROOT_W-1:0] in_root;
        logic [REM_W-1:0]  rem_shift;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic              take;

        if (k == 0)
        begin : g_first
            assign in_v    = i_valid;
            assign in_vec  = i_vec;
            assign in_bits = {i_vec.sum_sq, {(V_W-S_W){1'b0}}};
            assign in_rem  = '0;
            assign in_root = '0;
        end
        else
        begin : g_rest
            assign in_v    = valid_reg[k-1];
            assign in_vec  = vec_reg[k-1];
            assign in_bits = v_reg[k-1];
            assign in_rem  = rem_reg[k-1];
            assign in_root = root_reg[k-1];
        end

        always_comb
        begin
            rem_shift = {in_rem[REM_W-3:0], in_bits[V_W-1 -: 2]};
            trial     = {in_root, 2'b01};
            take      = (rem_shift >= trial);
            rem_next  = take ? (rem_shift - trial) : rem_shift;
            root_next = {in_root[ROOT_W-2:0], take};
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (rdy[k])
                valid_reg[k] <= in_v;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && in_v)
            begin
                vec_reg[k]  <= in_vec;
                v_reg[k]    <= {in_bits[V_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign o_valid = valid_reg[STAGES-1];
    assign o_vec   = vec_reg[STAGES-1];
    assign o_root  = root_reg[STAGES-1];

endmodule

// ===== design/rdz_scale.sv =====
// ----------------------------------------------------------------------------
// rdz_scale
// dead-zone compare and rescale products, three stages, forms the
// rounding numerator and denominator for both axes
// ----------------------------------------------------------------------------
module rdz_scale import rdz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DZ_W-1:0]   dead_zone,
    input  logic              i_valid,
    output logic              i_ready,
    input  rdz_vec_t          i_vec,
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_valid,
    input  logic              o_ready,
    output rdz_frac_t         o_frac
);

    // stage a: compare, mag^2, s*127
    logic               a_valid_reg;
    rdz_vec_t           a_vec_reg;
    logic               a_touched_reg;
    logic [ROOT_W-1:0]  a_n_reg;
    logic [MSQ_W-1:0]   a_msq_x_reg;
    logic [MSQ_W-1:0]   a_msq_y_reg;
    logic [SDEN_W-1:0]  a_sden_reg;
    // stage b: products
    logic               b_valid_reg;
    rdz_vec_t           b_vec_reg;
    logic               b_touched_reg;
    logic [PROD_W-1:0]  b_prod_x_reg;
    logic [PROD_W-1:0]  b_prod_y_reg;
    logic [DPROD_W-1:0] b_den_reg;
    // stage c: numerator / denominator select
    logic               c_valid_reg;
    rdz_frac_t          c_frac_reg;
    rdz_frac_t          c_frac_next;

    logic               a_rdy;
    logic               b_rdy;
    logic               c_rdy;
    logic [SDEN_W-1:0]  dzs;
    logic [16:0]        dz_comp;

    assign c_rdy   = !c_valid_reg || o_ready;
    assign b_rdy   = !b_valid_reg || c_rdy;
    assign a_rdy   = !a_valid_reg || b_rdy;
    assign i_ready = a_rdy;

    assign dzs     = {7'b0, dead_zone} * 23'd127;
    assign dz_comp = 17'h10000 - {1'b0, dead_zone};

    always_comb
    begin
        c_frac_next.touched = b_touched_reg;
        c_frac_next.neg_x   = b_vec_reg.neg_x;
        c_frac_next.neg_y   = b_vec_reg.neg_y;
        if (b_touched_reg && (b_vec_reg.sum_sq != '0))
        begin
            c_frac_next.num_x = {1'b0, b_prod_x_reg, 15'b0} + NUM_W'(b_den_reg);
            c_frac_next.num_y = {1'b0, b_prod_y_reg, 15'b0} + NUM_W'(b_den_reg);
            c_frac_next.den   = {b_den_reg, 1'b0};
        end
        else if (b_touched_reg)
        begin
            // zero radius: rounds to zero
            c_frac_next.num_x = NUM_W'(1);
            c_frac_next.num_y = NUM_W'(1);
            c_frac_next.den   = DEN_W'(2);
        end
        else
        begin
            // inside dead zone: 16384 * c / 127
            c_frac_next.num_x = NUM_W'({b_vec_reg.mag_x, 15'b0}) + NUM_W'(127);
            c_frac_next.num_y = NUM_W'({b_vec_reg.mag_y, 15'b0}) + NUM_W'(127);
            c_frac_next.den   = DEN_W'(254);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_valid_reg <= i_valid;
            if (b_rdy)
                b_valid_reg <= a_valid_reg;
            if (c_rdy)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && i_valid)
        begin
            a_vec_reg     <= i_vec;
            a_touched_reg <= (i_root >= {1'b0, dzs});
            a_n_reg       <= i_root - {1'b0, dzs};
            a_msq_x_reg   <= {7'b0, i_vec.mag_x} * {7'b0, i_vec.mag_x};
            a_msq_y_reg   <= {7'b0, i_vec.mag_y} * {7'b0, i_vec.mag_y};
            a_sden_reg    <= {7'b0, i_vec.sum_sq} * 23'd127;
        end
        if (b_rdy && a_valid_reg)
        begin
            b_vec_reg     <= a_vec_reg;
            b_touched_reg <= a_touched_reg;
            b_prod_x_reg  <= PROD_W'(a_msq_x_reg) * PROD_W'(a_n_reg);
            b_prod_y_reg  <= PROD_W'(a_msq_y_reg) * PROD_W'(a_n_reg);
            b_den_reg     <= DPROD_W'(a_sden_reg) * DPROD_W'(dz_comp);
        end
        if (c_rdy && b_valid_reg)
            c_frac_reg <= c_frac_next;
    end

    assign o_valid = c_valid_reg;
    assign o_frac  = c_frac_reg;

endmodule

// ===== design/rdz_div.sv =====
// ----------------------------------------------------------------------------
// rdz_div
// pipelined restoring divider, two axis lanes sharing one denominator,
// one quotient bit per stage with overflow flag
// ----------------------------------------------------------------------------
module rdz_div import rdz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      i_valid,
    output logic      i_ready,
    input  rdz_frac_t i_frac,
    output logic      o_valid,
    input  logic      o_ready,
    output rdz_quo_t  o_quo
);

    localparam int STAGES = Q_W;

    logic             valid_reg [STAGES];
    logic             rdy       [STAGES+1];
    rdz_flags_t       flags_reg [STAGES];
    logic [NUM_W-1:0] rem_x_reg [STAGES];
    logic [NUM_W-1:0] rem_y_reg [STAGES];
    logic [DEN_W-1:0] den_reg   [STAGES];
    logic [Q_W-1:0]   q_x_reg   [STAGES];
    logic [Q_W-1:0]   q_y_reg   [STAGES];

    assign rdy[STAGES] = o_ready;
    assign i_ready     = rdy[0];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic             in_v;
        rdz_flags_t       in_flags;
        logic [NUM_W-1:0] in_rx;
        logic [NUM_W-1:0] in_ry;
        logic [DEN_W-1:0] in_den;
        logic [Q_W-1:0]   in_qx;
        logic [Q_W-1:0]   in_qy;
        logic [DIV_W-1:0] dsh;
        logic             take_x;
        logic             take_y;

        if (k == 0)
        begin : g_first
            logic [DIV_W-1:0] dtop;
            assign dtop             = {i_frac.den, {(DIV_W-DEN_W){1'b0}}};
            assign in_v             = i_valid;
            assign in_flags.touched = i_frac.touched;
            assign in_flags.neg_x   = i_frac.neg_x;
            assign in_flags.neg_y   = i_frac.neg_y;
            assign in_flags.ovf_x   = ({2'b0, i_frac.num_x} >= dtop);
            assign in_flags.ovf_y   = ({2'b0, i_frac.num_y} >= dtop);
            assign in_rx            = i_frac.num_x;
            assign in_ry            = i_frac.num_y;
            assign in_den           = i_frac.den;
            assign in_qx            = '0;
            assign in_qy            = '0;
        end
        else
        begin : g_rest
            assign in_v     = valid_reg[k-1];
            assign in_flags = flags_reg[k-1];
            assign in_rx    = rem_x_reg[k-1];
            assign in_ry    = rem_y_reg[k-1];
            assign in_den   = den_reg[k-1];
            assign in_qx    = q_x_reg[k-1];
            assign in_qy    = q_y_reg[k-1];
        end

        assign dsh    = DIV_W'(in_den) << (STAGES - 1 - k);
        assign take_x = ({2'b0, in_rx} >= dsh);
        assign take_y = ({2'b0, in_ry} >= dsh);
        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (rdy[k])
                valid_reg[k] <= in_v;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && in_v)
            begin
                flags_reg[k] <= in_flags;
                den_reg[k]   <= in_den;
                rem_x_reg[k] <= take_x ? (in_rx - dsh[NUM_W-1:0]) : in_rx;
                rem_y_reg[k] <= take_y ? (in_ry - dsh[NUM_W-1:0]) : in_ry;
                q_x_reg[k]   <= {in_qx[Q_W-2:0], take_x};
                q_y_reg[k]   <= {in_qy[Q_W-2:0], take_y};
            end
        end
    end

    assign o_valid     = valid_reg[STAGES-1];
    assign o_quo.flags = flags_reg[STAGES-1];
    assign o_quo.q_x   = q_x_reg[STAGES-1];
    assign o_quo.q_y   = q_y_reg[STAGES-1];

endmodule

// ===== design/thumbstick_radial_dead_zone_unit.sv =====
// ----------------------------------------------------------------------------
// thumbstick_radial_dead_zone_unit
// scaled radial dead zone for one stick: centres two raw axes, takes the
// radius, rescales outside the dead zone and saturates to signed q2.14
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_ready       raw_x, raw_y
//  output    out_valid / out_ready     pad_touched, pad_pressed, pad_x, pad_y
//  config    cfg_wr_en                 cfg_index, cfg_wr_data
//
//  one transaction in per cycle while the output is not stalled: 24 root stages (one root
//  bit each), 3 scale stages, 16 divider stages (one quotient bit each) and
//  the output register
//  rst_n clears all valid bits and loads the config reset values
//  stalls ripple back stage by stage; empty stages keep filling while the
//  output waits, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module thumbstick_radial_dead_zone_unit import rdz_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // config write port
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [DZ_W-1:0]         cfg_wr_data,
    // input transactions
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [AX_W-1:0]         raw_x,
    input  logic [AX_W-1:0]         raw_y,
    // output transactions
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    pad_touched,
    output logic                    pad_pressed,
    output logic signed [OUT_W-1:0] pad_x,
    output logic signed [OUT_W-1:0] pad_y
);

    // config registers
    logic [DZ_W-1:0] dead_zone_reg;
    logic            tcp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DZ_RESET;
            tcp_reg       <= TCP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEAD_ZONE:   dead_zone_reg <= cfg_wr_data;
                REG_TOUCH_PRESS: tcp_reg       <= cfg_wr_data[0];
                default:         ;
            endcase
        end
    end

    // centring: magnitude and sign of raw - 127, plus sum of squares
    rdz_vec_t in_vec;

    always_comb
    begin
        in_vec.neg_x  = (raw_x < CENTER);
        in_vec.neg_y  = (raw_y < CENTER);
        in_vec.mag_x  = in_vec.neg_x ? (CENTER - raw_x) : (raw_x - CENTER);
        in_vec.mag_y  = in_vec.neg_y ? (CENTER - raw_y) : (raw_y - CENTER);
        in_vec.sum_sq = ({8'b0, in_vec.mag_x} * {8'b0, in_vec.mag_x})
                      + ({8'b0, in_vec.mag_y} * {8'b0, in_vec.mag_y});
    end

    // radius
    logic              sq_valid;
    logic              sq_ready;
    rdz_vec_t          sq_vec;
    logic [ROOT_W-1:0] sq_root;

    rdz_sqrt u_sqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .i_valid (in_valid),
        .i_ready (in_ready),
        .i_vec   (in_vec),
        .o_valid (sq_valid),
        .o_ready (sq_ready),
        .o_vec   (sq_vec),
        .o_root  (sq_root)
    );

    // dead-zone test and rescale factors
    logic      sc_valid;
    logic      sc_ready;
    rdz_frac_t sc_frac;

    rdz_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dead_zone (dead_zone_reg),
        .i_valid   (sq_valid),
        .i_ready   (sq_ready),
        .i_vec     (sq_vec),
        .i_root    (sq_root),
        .o_valid   (sc_valid),
        .o_ready   (sc_ready),
        .o_frac    (sc_frac)
    );

    // rounded quotient per axis
    logic     dv_valid;
    logic     dv_ready;
    rdz_quo_t dv_quo;

    rdz_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .i_valid (sc_valid),
        .i_ready (sc_ready),
        .i_frac  (sc_frac),
        .o_valid (dv_valid),
        .o_ready (dv_ready),
        .o_quo   (dv_quo)
    );

    // saturation and sign, output register
    logic             out_valid_reg;
    logic             touched_reg;
    logic             pressed_reg;
    logic [OUT_W-1:0] x_reg;
    logic [OUT_W-1:0] y_reg;
    logic [OUT_W-1:0] x_next;
    logic [OUT_W-1:0] y_next;

    function automatic logic [OUT_W-1:0] sat_q14(input logic neg, input logic ovf,
                                                 input logic [Q_W-1:0] q);
        logic [OUT_W-1:0] res;
        if (neg)
        begin
            // magnitude above 32768 clamps to the most negative code
            if (ovf || (q[Q_W-1] && (q[Q_W-2:0] != '0)))
                res = {1'b1, {(OUT_W-1){1'b0}}};
            else
                res = OUT_W'(-q);
        end
        else
        begin
            if (ovf || q[Q_W-1])
                res = {1'b0, {(OUT_W-1){1'b1}}};
            else
                res = OUT_W'(q);
        end
        return res;
    endfunction

    assign x_next   = sat_q14(dv_quo.flags.neg_x, dv_quo.flags.ovf_x, dv_quo.q_x);
    assign y_next   = sat_q14(dv_quo.flags.neg_y, dv_quo.flags.ovf_y, dv_quo.q_y);
    assign dv_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dv_ready)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready && dv_valid)
        begin
            touched_reg <= dv_quo.flags.touched;
            pressed_reg <= dv_quo.flags.touched & tcp_reg;
            x_reg       <= x_next;
            y_reg       <= y_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pad_touched = touched_reg;
    assign pad_pressed = pressed_reg;
    assign pad_x       = x_reg;
    assign pad_y       = y_reg;

    // a press is always a touch
    a_press_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!pad_pressed || pad_touched))
        else $error("pad_pressed without pad_touched");

    // with touch-as-press set and config stable, press follows touch
    a_press_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tcp_reg && $stable(tcp_reg)) |-> (pad_pressed == pad_touched))
        else $error("pad_pressed differs from pad_touched");

    // inside the dead zone the centred value passes: at most 16384*128/127
    a_dead_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pad_touched) |->
            (pad_x <= 16'sd16513 && pad_x >= -16'sd16384 &&
             pad_y <= 16'sd16513 && pad_y >= -16'sd16384))
        else $error("dead zone output out of range");

endmodule

// ===== sim/thumbstick_radial_dead_zone_unit_test.sv =====
// ----------------------------------------------------------------------------
// thumbstick_radial_dead_zone_unit_test
// self-checking bench: directed table of stick positions and dead-zone
// settings, then random positions under several settings; fixed rows use hand-read
// results, all others an integer model of the radial dead zone with rescaling
// ----------------------------------------------------------------------------
module thumbstick_radial_dead_zone_unit_test;
    import rdz_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_PAIRS = 450;

    // one output transaction
    typedef struct packed {
        logic        touched;
        logic        pressed;
        logic [15:0] x;
        logic [15:0] y;
    } pad_t;

    // one row of the directed table; fixed rows carry a hand-read result
    typedef struct packed {
        logic [15:0] dz;
        logic        tcp;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic        fixed;
        pad_t        pad;
    } dir_row_t;

    localparam int N_DIR = 23;
    dir_row_t directed [0:N_DIR-1] = '{
        // reset settings: centre stays inside the dead zone
        '{16'd6554,  1'b1, 8'd127, 8'd127, 1'b1, '{1'b0, 1'b0, 16'h0000, 16'h0000}},
        '{16'd6554,  1'b1, 8'd255, 8'd127, 1'b0, '0},
        '{16'd6554,  1'b1, 8'd0,   8'd0,   1'b0, '0},
        '{16'd6554,  1'b1, 8'd0,   8'd255, 1'b0, '0},
        '{16'd6554,  1'b1, 8'd255, 8'd255, 1'b0, '0},
        '{16'd6554,  1'b1, 8'd128, 8'd130, 1'b0, '0},
        '{16'd6554,  1'b1, 8'd140, 8'd127, 1'b0, '0},
        '{16'd6554,  1'b1, 8'd255, 8'd0,   1'b0, '0},
        // zero dead zone: zero radius counts as touched, outputs zero
        '{16'd0,     1'b0, 8'd127, 8'd127, 1'b1, '{1'b1, 1'b0, 16'h0000, 16'h0000}},
        '{16'd0,     1'b0, 8'd0,   8'd127, 1'b0, '0},
        '{16'd0,     1'b0, 8'd200, 8'd50,  1'b0, '0},
        '{16'd0,     1'b1, 8'd127, 8'd127, 1'b1, '{1'b1, 1'b1, 16'h0000, 16'h0000}},
        // full-scale dead zone: rescale factor blows up and three of these six rows saturate
        '{16'd65535, 1'b1, 8'd255, 8'd127, 1'b1, '{1'b1, 1'b1, 16'h7FFF, 16'h0000}},
        '{16'd65535, 1'b1, 8'd0,   8'd127, 1'b1, '{1'b1, 1'b1, 16'hC000, 16'h0000}},
        '{16'd65535, 1'b1, 8'd127, 8'd0,   1'b1, '{1'b1, 1'b1, 16'h0000, 16'hC000}},
        '{16'd65535, 1'b1, 8'd0,   8'd0,   1'b0, '0},
        '{16'd65535, 1'b1, 8'd127, 8'd128, 1'b0, '0},
        '{16'd65535, 1'b1, 8'd255, 8'd255, 1'b0, '0},
        // half-scale dead zone, press off
        '{16'd32768, 1'b0, 8'd180, 8'd90,  1'b0, '0},
        '{16'd32768, 1'b0, 8'd127, 8'd200, 1'b0, '0},
        '{16'd32768, 1'b0, 8'd64,  8'd64,  1'b0, '0},
        '{16'd32768, 1'b0, 8'd127, 8'd254, 1'b0, '0},
        '{16'd32768, 1'b0, 8'd1,   8'd253, 1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = REG_DEAD_ZONE;
    logic [DZ_W-1:0]   cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [AX_W-1:0]   raw_x = '0;
    logic [AX_W-1:0]   raw_y = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              pad_touched;
    logic              pad_pressed;
    logic signed [15:0] pad_x;
    logic signed [15:0] pad_y;

    // model copy of the registers
    logic [15:0] cur_dz  = DZ_RESET;
    logic        cur_tcp = TCP_RESET;

    pad_t pending_pads [$];
    int   errors = 0;
    int   cycles = 0;
    int   burst_left = 1;
    bit   long_hold_req = 0;

    thumbstick_radial_dead_zone_unit DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // model
    // --------------------------------------------------------------------

    // floor of the square root, one result bit per step
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // round to nearest, halves away from zero, then signed 16-bit saturate
    function automatic logic [15:0] round_q14(bit neg, longint unsigned num,
                                              longint unsigned den);
        longint unsigned q;
        q = (2 * num + den) / (2 * den);
        if (neg)
        begin
            if (q > 32768)
                q = 32768;
            return 16'(-q);
        end
        if (q > 32767)
            q = 32767;
        return 16'(q);
    endfunction

    function automatic pad_t dead_zone_response(logic [7:0] rx, logic [7:0] ry,
                                                logic [15:0] dz, logic tcp);
        int cx;
        int cy;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned s;
        longint unsigned r;
        longint unsigned dzs;
        longint unsigned n;
        longint unsigned den;
        pad_t p;
        cx = int'(rx) - 127;
        cy = int'(ry) - 127;
        mx = longint'((cx < 0) ? -cx : cx);
        my = longint'((cy < 0) ? -cy : cy);
        s = mx * mx + my * my;
        r = int_sqrt(s << 32);
        dzs = 127 * longint'(dz);
        p.touched = (r >= dzs);
        p.pressed = p.touched & tcp;
        if (p.touched && s == 0)
        begin
            p.x = '0;
            p.y = '0;
        end
        else if (p.touched)
        begin
            // rescale outside the dead zone
            n = r - dzs;
            den = s * 127 * (65536 - longint'(dz));
            p.x = round_q14(cx < 0, 16384 * mx * mx * n, den);
            p.y = round_q14(cy < 0, 16384 * my * my * n, den);
        end
        else
        begin
            p.x = round_q14(cx < 0, 16384 * mx, 127);
            p.y = round_q14(cy < 0, 16384 * my, 127);
        end
        return p;
    endfunction

    // --------------------------------------------------------------------
    // input side
    // --------------------------------------------------------------------

    // offer one transaction; called right after a rising edge
    task automatic send_pair(logic [7:0] rx, logic [7:0] ry, bit fixed, pad_t fixed_pad);
        int gap;
        in_valid <= 1'b1;
        raw_x <= rx;
        raw_y <= ry;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pads.push_back(fixed ? fixed_pad : dead_zone_response(rx, ry, cur_dz, cur_tcp));
        burst_left--;
        if (burst_left <= 0)
        begin
            // random gap; only drop valid when the gap is real
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // wait for every pending transaction, leaving valid low
    task automatic drain;
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_pads.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write both registers on back-to-back edges, pipeline idle
    task automatic write_config(logic [15:0] dz, logic tcp);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEAD_ZONE;
        cfg_wr_data <= dz;
        @(posedge clk);
        cfg_index <= REG_TOUCH_PRESS;
        cfg_wr_data <= {15'd0, tcp};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        cur_dz = dz;
        cur_tcp = tcp;
    endtask

    // --------------------------------------------------------------------
    // output side: stall pattern, long hold-off and checking
    // --------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        pad_t want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pads.size() == 0)
            begin
                $display("%0t: unexpected transaction x=%h y=%h", $time, pad_x, pad_y);
                errors++;
            end
            else
            begin
                want = pending_pads.pop_front();
                if (pad_touched !== want.touched)
                begin
                    $display("%0t: pad_touched expected %b actual %b", $time,
                             want.touched, pad_touched);
                    errors++;
                end
                if (pad_pressed !== want.pressed)
                begin
                    $display("%0t: pad_pressed expected %b actual %b", $time,
                             want.pressed, pad_pressed);
                    errors++;
                end
                if (pad_x !== want.x)
                begin
                    $display("%0t: pad_x expected %h actual %h", $time, want.x, pad_x);
                    errors++;
                end
                if (pad_y !== want.y)
                begin
                    $display("%0t: pad_y expected %h actual %h", $time, want.y, pad_y);
                    errors++;
                end
            end
        end

        // long hold-off so the pipeline fills and backs up the input
        if (long_hold_req && hold_left == 0)
        begin
            long_hold_req = 0;
            hold_left = LONG_HOLD;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 80);
        end
        else
            mode_left--;

        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_mode == 0)
            out_ready <= 1'b1;
        else if (stall_mode == 1)
            out_ready <= 1'($urandom_range(0, 1));
        else
            out_ready <= ($urandom_range(0, 3) == 0);
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // stimulus
    // --------------------------------------------------------------------
    initial
    begin
        logic [15:0] dz;
        logic [7:0] rx;
        logic [7:0] ry;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, rewriting the registers when a row changes them
        for (int i = 0; i < N_DIR; i++)
        begin
            if (directed[i].dz != cur_dz || directed[i].tcp != cur_tcp)
                write_config(directed[i].dz, directed[i].tcp);
            send_pair(directed[i].rx, directed[i].ry, directed[i].fixed, directed[i].pad);
        end

        // random part in phases, each with its own settings
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i % 75 == 0)
            begin
                case ($urandom_range(0, 5))
                    0: dz = 16'd0;
                    1: dz = 16'd65535;
                    2: dz = 16'($urandom_range(0, 4000));
                    3: dz = 16'($urandom_range(60000, 65535));
                    default: dz = 16'($urandom_range(0, 65535));
                endcase
                write_config(dz, 1'($urandom_range(0, 1)));
                if (i == 150)
                    long_hold_req = 1;
            end
            // mix of full-range and near-centre positions
            if ($urandom_range(0, 3) == 0)
            begin
                rx = 8'($urandom_range(110, 145));
                ry = 8'($urandom_range(110, 145));
            end
            else
            begin
                rx = 8'($urandom_range(0, 255));
                ry = 8'($urandom_range(0, 255));
            end
            send_pair(rx, ry, 1'b0, '0);
        end

        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
